FILE: src/dali_address_search_commissioner_macros.svh
// Assertion helpers for the checker file.
`ifndef DALI_ADDRESS_SEARCH_COMMISSIONER_MACROS_SVH
`define DALI_ADDRESS_SEARCH_COMMISSIONER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DASC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DASC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dasc_pkg.sv
`default_nettype none
package dasc_pkg;

  // Request kinds on the input stream
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_ANSWER = 1'b1;

  // Forward frame first bytes
  localparam logic [7:0] OP_RESET       = 8'h20;
  localparam logic [7:0] OP_TERMINATE   = 8'hA1;
  localparam logic [7:0] OP_INITIALISE  = 8'hA5;
  localparam logic [7:0] OP_RANDOMISE   = 8'hA7;
  localparam logic [7:0] OP_COMPARE     = 8'hA9;
  localparam logic [7:0] OP_WITHDRAW    = 8'hAB;
  localparam logic [7:0] OP_SEARCH_H    = 8'hB1;
  localparam logic [7:0] OP_SEARCH_M    = 8'hB3;
  localparam logic [7:0] OP_SEARCH_L    = 8'hB5;
  localparam logic [7:0] OP_PROG_SHORT  = 8'hB7;
  localparam logic [7:0] OP_QUERY_SHORT = 8'hBB;

  // Pause classes after a frame
  localparam logic [1:0] GAP_SETTLE  = 2'd0;
  localparam logic [1:0] GAP_COMPARE = 2'd1;
  localparam logic [1:0] GAP_PROGRAM = 2'd2;

  // Frame tag wraps after this value
  localparam logic [7:0] TAG_MAX = 8'd254;

  // Short address reported when a query gets no answer
  localparam logic [6:0] SHORT_NONE = 7'h7F;

  // Configuration register indexes
  localparam logic [1:0] REG_READONLY  = 2'd0;
  localparam logic [1:0] REG_SKIP_RAND = 2'd1;
  localparam logic [1:0] REG_LIMIT     = 2'd2;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic       readonly_mode;
    logic       skip_randomise;
    logic [6:0] short_limit;
  } cfg_t;

  // Classified request handed from the front to the sequencer
  typedef struct packed {
    logic       kind;
    logic       seen;
    logic [6:0] rd_short;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  frame_address;
    logic [7:0]  frame_data;
    logic [7:0]  frame_tag;
    logic [1:0]  gap_class;
    logic        expects_answer;
    logic [23:0] found_address;
    logic [6:0]  assigned_short;
    logic        found_valid;
    logic        done_res;
    logic        last;
  } frame_t;

endpackage
`default_nettype wire

FILE: src/dali_address_search_commissioner.sv
`default_nettype none
// DALI random-address commissioning sequencer. A start request (tuser 0) makes the
// block send reset, initialise and (unless skipped or read-only) randomise frames,
// then search the lowest random address by compare queries: the top address, the
// one below it, then bisection, one answer transaction (tuser 1) per frame flagged
// expects_answer. Each device found is programmed with the next short address (or
// asked for it in read-only mode) and withdrawn; the run ends with a terminate
// frame. Input requests pass through a two-entry queue to the frame sequencer,
// which sends one frame per clock while the output is not stalled, plus one decision
// step per request and one more for a bisection step or a new short address. The
// queue takes the next request while frames are still going out.
module dali_address_search_commissioner
  import dasc_pkg::*;
#(
  parameter int ADDRESS_BITS = 24,
  parameter int SHORT_SLOTS  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // answer_seen[0], answer_data[8:1]
  input  wire logic [0:0]  s_tuser,  // req_type[0]
  // Frames
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,  // frame_address[7:0], frame_data[15:8],
                                     // frame_tag[23:16], gap_class[25:24],
                                     // expects_answer[26], found_address[50:27],
                                     // assigned_short[57:51], found_valid[58],
                                     // done_res[59]
  output logic             m_tlast
);

  cfg_t   cfg;
  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_ready;
  frame_t frame;

  dasc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dasc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser[0]),
    .in_seen   (s_tdata[0]),
    .in_data   (s_tdata[8:1]),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dasc_back #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .SHORT_SLOTS  (SHORT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_frame (frame)
  );

  // Pack the frame onto the stream
  assign m_tdata = {4'd0, frame.done_res, frame.found_valid, frame.assigned_short,
                    frame.found_address, frame.expects_answer, frame.gap_class,
                    frame.frame_tag, frame.frame_data, frame.frame_address};
  assign m_tlast = frame.last;

endmodule
`default_nettype wire

FILE: src/dasc_regs.sv
`default_nettype none
module dasc_regs
  import dasc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.readonly_mode  <= 1'b0;
      cfg.skip_randomise <= 1'b0;
      cfg.short_limit    <= LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_READONLY:  cfg.readonly_mode  <= pwdata[0];
        REG_SKIP_RAND: cfg.skip_randomise <= pwdata[0];
        REG_LIMIT:     cfg.short_limit    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_READONLY:  prdata = {31'd0, cfg.readonly_mode};
      REG_SKIP_RAND: prdata = {31'd0, cfg.skip_randomise};
      REG_LIMIT:     prdata = {25'd0, cfg.short_limit};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/dasc_front.sv
`default_nettype none
module dasc_front
  import dasc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic       in_seen,
  input  wire logic [7:0] in_data,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // Classify the request and pre-decode the short address reply
  always_comb begin
    cmd_in.kind     = in_kind ? CMD_ANSWER : CMD_START;
    cmd_in.seen     = in_seen;
    cmd_in.rd_short = in_seen ? in_data[7:1] : SHORT_NONE;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slot[rptr];

  // Two-entry queue toward the sequencer
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/dasc_back.sv
`default_nettype none
module dasc_back
  import dasc_pkg::*;
#(
  parameter int ADDRESS_BITS = 24,
  parameter int SHORT_SLOTS  = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output frame_t    out_frame
);

  localparam int AW = ADDRESS_BITS;
  localparam logic [AW-1:0] ADDR_TOP  = {AW{1'b1}};
  localparam logic [AW:0]   ADDR_SPAN = {1'b1, {AW{1'b0}}};
  localparam logic [6:0]    SLOTS     = 7'(SHORT_SLOTS);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_SLOT  = 4'd2;
  localparam logic [3:0] S_MID   = 4'd3;
  localparam logic [3:0] S_QUERY = 4'd4;
  localparam logic [3:0] S_PROG  = 4'd5;
  localparam logic [3:0] S_WDRAW = 4'd6;
  localparam logic [3:0] S_QSHRT = 4'd7;
  localparam logic [3:0] S_TERM  = 4'd8;

  // Search phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_PROBE_TOP  = 3'd1;
  localparam logic [2:0] PH_PROBE_NEXT = 3'd2;
  localparam logic [2:0] PH_BISECT     = 3'd3;
  localparam logic [2:0] PH_CHECK      = 3'd4;
  localparam logic [2:0] PH_READ_SHORT = 3'd5;

  logic [3:0]    seq;
  logic [2:0]    phase;
  logic [AW:0]   low_limit;
  logic [AW:0]   high_limit;
  logic [AW-1:0] search_addr;
  logic [AW-1:0] q_addr;
  logic          q_loc;
  logic [1:0]    q_idx;
  logic [2:0]    init_idx;
  logic          init_six;
  logic [6:0]    short_counter;
  logic [6:0]    ab_short;
  logic [7:0]    frame_counter;
  logic [7:0]    frame_counter_next;

  logic          out_free;
  logic          fr_emit;
  frame_t        fr;
  logic [23:0]   q_addr24;
  logic [AW+1:0] mid_sum;
  logic [AW-1:0] mid;
  logic [6:0]    eff_limit;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (seq == S_IDLE);
  assign q_addr24  = 24'(q_addr);
  assign mid_sum   = {1'b0, low_limit} + {1'b0, high_limit};
  assign mid       = mid_sum[AW:1];
  assign eff_limit = (cfg.short_limit < SLOTS) ? cfg.short_limit : SLOTS;
  assign frame_counter_next = (frame_counter == TAG_MAX) ? 8'd0 : frame_counter + 8'd1;

  // Build the frame for the current step
  always_comb begin
    fr                = '0;
    fr_emit           = 1'b0;
    fr.frame_tag      = frame_counter;
    fr.gap_class      = GAP_SETTLE;
    case (seq)
      S_INIT: begin
        fr_emit = 1'b1;
        case (init_idx[2:1])
          2'd0:    fr.frame_address = OP_RESET;
          2'd1:    fr.frame_address = OP_INITIALISE;
          default: fr.frame_address = OP_RANDOMISE;
        endcase
      end
      S_QUERY: begin
        fr_emit      = 1'b1;
        fr.gap_class = GAP_COMPARE;
        case (q_idx)
          2'd0: begin
            fr.frame_address = OP_SEARCH_H;
            fr.frame_data    = q_addr24[23:16];
          end
          2'd1: begin
            fr.frame_address = OP_SEARCH_M;
            fr.frame_data    = q_addr24[15:8];
          end
          2'd2: begin
            fr.frame_address = OP_SEARCH_L;
            fr.frame_data    = q_addr24[7:0];
          end
          default: begin
            fr.frame_address  = OP_COMPARE;
            fr.expects_answer = !q_loc;
            fr.last           = !q_loc;
          end
        endcase
      end
      S_PROG: begin
        fr_emit          = 1'b1;
        fr.gap_class     = GAP_PROGRAM;
        fr.frame_address = OP_PROG_SHORT;
        fr.frame_data    = {short_counter, 1'b1};
      end
      S_WDRAW: begin
        fr_emit           = 1'b1;
        fr.gap_class      = GAP_COMPARE;
        fr.frame_address  = OP_WITHDRAW;
        fr.found_valid    = 1'b1;
        fr.found_address  = 24'(search_addr);
        fr.assigned_short = ab_short;
      end
      S_QSHRT: begin
        fr_emit           = 1'b1;
        fr.gap_class      = GAP_PROGRAM;
        fr.frame_address  = OP_QUERY_SHORT;
        fr.expects_answer = 1'b1;
        fr.last           = 1'b1;
      end
      S_TERM: begin
        fr_emit          = 1'b1;
        fr.frame_address = OP_TERMINATE;
        fr.done_res      = 1'b1;
        fr.last          = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: load a frame when the slot is free
  always_ff @(posedge clk) begin
    if (fr_emit && out_free) begin
      out_frame <= fr;
    end
  end

  // Sequencer and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= S_IDLE;
      phase         <= PH_IDLE;
      low_limit     <= '0;
      high_limit    <= ADDR_SPAN;
      search_addr   <= ADDR_TOP;
      short_counter <= 7'd0;
      frame_counter <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= (fr_emit && out_free) || (out_valid && !out_ready);
      if (fr_emit && out_free) begin
        frame_counter <= frame_counter_next;
      end
      case (seq)
        S_IDLE: begin
          if (cmd_valid) begin
            q_idx <= 2'd0;
            if (cmd.kind == CMD_START) begin
              short_counter <= 7'd0;
              init_idx      <= 3'd0;
              init_six      <= !cfg.skip_randomise && !cfg.readonly_mode;
              seq           <= S_INIT;
            end else begin
              case (phase)
                PH_PROBE_TOP: begin
                  if (!cmd.seen) begin
                    seq <= S_TERM;
                  end else begin
                    q_addr <= ADDR_TOP - 1'b1;
                    q_loc  <= 1'b0;
                    phase  <= PH_PROBE_NEXT;
                    seq    <= S_QUERY;
                  end
                end
                PH_PROBE_NEXT: begin
                  if (!cmd.seen) begin
                    search_addr <= ADDR_TOP;
                    q_addr      <= ADDR_TOP;
                    q_loc       <= 1'b1;
                    seq         <= S_QUERY;
                  end else begin
                    low_limit  <= '0;
                    high_limit <= ADDR_SPAN;
                    seq        <= S_MID;
                  end
                end
                PH_BISECT: begin
                  if (cmd.seen) begin
                    if (search_addr == '0) begin
                      q_addr <= search_addr;
                      q_loc  <= 1'b1;
                    end else begin
                      q_addr <= search_addr - 1'b1;
                      q_loc  <= 1'b0;
                      phase  <= PH_CHECK;
                    end
                    seq <= S_QUERY;
                  end else begin
                    low_limit <= {1'b0, search_addr};
                    seq       <= S_MID;
                  end
                end
                PH_CHECK: begin
                  if (!cmd.seen) begin
                    q_addr <= search_addr;
                    q_loc  <= 1'b1;
                    seq    <= S_QUERY;
                  end else begin
                    high_limit <= {1'b0, search_addr};
                    seq        <= S_MID;
                  end
                end
                PH_READ_SHORT: begin
                  ab_short <= cmd.rd_short;
                  seq      <= S_WDRAW;
                end
                default: ;
              endcase
            end
          end
        end
        S_INIT: begin
          if (out_free) begin
            if (init_idx == (init_six ? 3'd5 : 3'd3)) seq <= S_SLOT;
            else init_idx <= init_idx + 3'd1;
          end
        end
        S_SLOT: begin
          if (short_counter >= eff_limit) begin
            seq <= S_TERM;
          end else begin
            low_limit   <= '0;
            high_limit  <= ADDR_SPAN;
            search_addr <= ADDR_TOP;
            q_addr      <= ADDR_TOP;
            q_loc       <= 1'b0;
            q_idx       <= 2'd0;
            phase       <= PH_PROBE_TOP;
            seq         <= S_QUERY;
          end
        end
        S_MID: begin
          search_addr <= mid;
          q_addr      <= mid;
          q_loc       <= 1'b0;
          q_idx       <= 2'd0;
          phase       <= PH_BISECT;
          seq         <= S_QUERY;
        end
        S_QUERY: begin
          if (out_free) begin
            if (q_idx == 2'd3) begin
              if (!q_loc) seq <= S_IDLE;
              else if (cfg.readonly_mode) seq <= S_QSHRT;
              else seq <= S_PROG;
            end else begin
              q_idx <= q_idx + 2'd1;
            end
          end
        end
        S_PROG: begin
          if (out_free) begin
            ab_short <= short_counter;
            seq      <= S_WDRAW;
          end
        end
        S_WDRAW: begin
          if (out_free) begin
            short_counter <= short_counter + 7'd1;
            seq           <= S_SLOT;
          end
        end
        S_QSHRT: begin
          if (out_free) begin
            phase <= PH_READ_SHORT;
            seq   <= S_IDLE;
          end
        end
        S_TERM: begin
          if (out_free) begin
            phase <= PH_IDLE;
            seq   <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/dasc_checker.sv
`default_nettype none
`include "dali_address_search_commissioner_macros.svh"
module dasc_checker
  import dasc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tlast
);

  logic withdraw_ok;

  assign withdraw_ok = !m_tlast && (m_tdata[25:24] == GAP_COMPARE);

  // Stalled frame stays offered and unchanged
  `DASC_ASSERT(a_hold_valid, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "frame dropped")
  `DASC_ASSERT(a_hold_data, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "frame changed")

  // Terminate always closes the run of frames
  `DASC_ASSERT(a_done_last, clk, rst, m_tvalid && m_tdata[59] |-> m_tlast, "terminate not last")

  // Withdraw of a found device is a compare-gap frame and never ends a request
  `DASC_ASSERT(a_found_mid, clk, rst, m_tvalid && m_tdata[58] |-> withdraw_ok, "bad withdraw")

  // Output empties after reset
  `DASC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "valid after reset")

endmodule

bind dali_address_search_commissioner dasc_checker u_dasc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: bench/dali_address_search_commissioner_tb.sv
`timescale 1ns / 100ps
module dali_address_search_commissioner_tb
  import dasc_pkg::*;
();

  localparam int          SLOT_COUNT   = 64;
  localparam logic [23:0] TOP_ADDR     = 24'hFFFFFF;
  localparam logic [24:0] ADDR_SPAN    = 25'h1000000;
  localparam int          MAX_FRAMES   = 12;
  localparam int          STIM_VIEW    = 0;
  localparam int          CHECK_VIEW   = 1;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          RANDOM_ITEMS = 140;
  localparam int          IDLE_PCT     = 24;

  typedef enum logic [3:0] {
    SRCH_IDLE,
    SRCH_PROBE_TOP,
    SRCH_PROBE_NEXT,
    SRCH_BISECT,
    SRCH_CHECK_BELOW,
    SRCH_READ_SHORT
  } search_stage_t;

  typedef enum logic [1:0] {
    AWAIT_NONE,
    AWAIT_COMPARE,
    AWAIT_SHORT
  } bus_wait_t;

  typedef struct packed {
    search_stage_t stage;
    logic [24:0]   lo_bound;
    logic [24:0]   hi_bound;
    logic [23:0]   probe;
    logic [6:0]    slot;
    logic [7:0]    tag;
  } search_view_t;

  typedef struct packed {
    logic       kind;
    logic       seen;
    logic [7:0] data;
  } request_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // answer_seen[0], answer_data[8:1]
  logic [0:0]  s_tuser  = '0;  // req_type[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // frame_address[7:0], frame_data[15:8], frame_tag[23:16],
                               // gap_class[25:24], expects_answer[26],
                               // found_address[50:27], assigned_short[57:51],
                               // found_valid[58], done_res[59]
  logic        m_tlast;

  // Two copies of the sequencer: one steers the stimulus, one predicts the block
  search_view_t view [2];
  cfg_t         cfg;
  frame_t       fresh_frames [$];
  frame_t       pending_frames [$];
  request_t     request_q [$];
  request_t     next_req;
  logic [23:0]  dev_addr [$];
  logic [6:0]   dev_short [$];
  logic [23:0]  bus_addr = '0;
  bus_wait_t    bus_wait = AWAIT_NONE;
  logic         calm = 1'b0;
  int           queued_count = 0;
  int           accepted_count = 0;
  int           live_items = 0;
  int           mismatches = 0;

  dali_address_search_commissioner dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sequencer predictor

  function automatic void clear_view(int v);
    view[v].stage    = SRCH_IDLE;
    view[v].lo_bound = '0;
    view[v].hi_bound = ADDR_SPAN;
    view[v].probe    = TOP_ADDR;
    view[v].slot     = '0;
    view[v].tag      = '0;
  endfunction

  function automatic void put_frame(int v, logic [7:0] op, logic [7:0] arg, logic [1:0] gap,
                                    logic ans, logic fv, logic [23:0] faddr,
                                    logic [6:0] fshort, logic fin);
    frame_t f;
    if (fresh_frames.size() >= MAX_FRAMES) return;
    f.frame_address  = op;
    f.frame_data     = arg;
    f.frame_tag      = view[v].tag;
    f.gap_class      = gap;
    f.expects_answer = ans;
    f.found_address  = faddr;
    f.assigned_short = fshort;
    f.found_valid    = fv;
    f.done_res       = fin;
    f.last           = 1'b0;
    fresh_frames.push_back(f);
    // the tag skips 255
    view[v].tag = (view[v].tag >= TAG_MAX) ? 8'd0 : view[v].tag + 8'd1;
  endfunction

  function automatic void send_compare(int v, logic [23:0] addr, logic ans);
    put_frame(v, OP_SEARCH_H, addr[23:16], GAP_COMPARE, 1'b0, 1'b0, '0, '0, 1'b0);
    put_frame(v, OP_SEARCH_M, addr[15:8], GAP_COMPARE, 1'b0, 1'b0, '0, '0, 1'b0);
    put_frame(v, OP_SEARCH_L, addr[7:0], GAP_COMPARE, 1'b0, 1'b0, '0, '0, 1'b0);
    put_frame(v, OP_COMPARE, 8'h00, GAP_COMPARE, ans, 1'b0, '0, '0, 1'b0);
  endfunction

  function automatic void open_slot(int v);
    logic [6:0] lim;
    lim = (cfg.short_limit < SLOT_COUNT) ? cfg.short_limit : 7'(SLOT_COUNT);
    if (view[v].slot >= lim) begin
      put_frame(v, OP_TERMINATE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b1);
      view[v].stage = SRCH_IDLE;
    end else begin
      view[v].lo_bound = '0;
      view[v].hi_bound = ADDR_SPAN;
      view[v].probe    = TOP_ADDR;
      send_compare(v, TOP_ADDR, 1'b1);
      view[v].stage = SRCH_PROBE_TOP;
    end
  endfunction

  function automatic void next_slot(int v);
    view[v].slot = view[v].slot + 7'd1;
    open_slot(v);
  endfunction

  function automatic void halve(int v);
    logic [25:0] sum;
    sum = {1'b0, view[v].lo_bound} + {1'b0, view[v].hi_bound};
    view[v].probe = sum[24:1];
    send_compare(v, view[v].probe, 1'b1);
    view[v].stage = SRCH_BISECT;
  endfunction

  // Reselect the located device, then program or query its short address
  function automatic void settle_found(int v);
    send_compare(v, view[v].probe, 1'b0);
    if (cfg.readonly_mode) begin
      put_frame(v, OP_QUERY_SHORT, 8'h00, GAP_PROGRAM, 1'b1, 1'b0, '0, '0, 1'b0);
      view[v].stage = SRCH_READ_SHORT;
      return;
    end
    put_frame(v, OP_PROG_SHORT, {view[v].slot, 1'b1}, GAP_PROGRAM, 1'b0, 1'b0, '0, '0, 1'b0);
    put_frame(v, OP_WITHDRAW, 8'h00, GAP_COMPARE, 1'b0, 1'b1, view[v].probe, view[v].slot,
              1'b0);
    next_slot(v);
  endfunction

  function automatic void predict_frames(int v, logic kind, logic seen, logic [7:0] data);
    frame_t f;
    fresh_frames.delete();
    if (kind == CMD_START) begin
      put_frame(v, OP_RESET, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
      put_frame(v, OP_RESET, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
      put_frame(v, OP_INITIALISE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
      put_frame(v, OP_INITIALISE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
      if (!cfg.skip_randomise && !cfg.readonly_mode) begin
        put_frame(v, OP_RANDOMISE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
        put_frame(v, OP_RANDOMISE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b0);
      end
      view[v].slot = '0;
      open_slot(v);
    end else begin
      case (view[v].stage)
        SRCH_PROBE_TOP: begin
          if (!seen) begin
            put_frame(v, OP_TERMINATE, 8'h00, GAP_SETTLE, 1'b0, 1'b0, '0, '0, 1'b1);
            view[v].stage = SRCH_IDLE;
          end else begin
            send_compare(v, TOP_ADDR - 24'd1, 1'b1);
            view[v].stage = SRCH_PROBE_NEXT;
          end
        end
        SRCH_PROBE_NEXT: begin
          // no answer below the top: the device sits at the top address
          if (!seen) begin
            view[v].probe = TOP_ADDR;
            settle_found(v);
          end else begin
            view[v].lo_bound = '0;
            view[v].hi_bound = ADDR_SPAN;
            halve(v);
          end
        end
        SRCH_BISECT: begin
          if (seen) begin
            if (view[v].probe == '0) begin
              settle_found(v);
            end else begin
              send_compare(v, view[v].probe - 24'd1, 1'b1);
              view[v].stage = SRCH_CHECK_BELOW;
            end
          end else begin
            view[v].lo_bound = {1'b0, view[v].probe};
            halve(v);
          end
        end
        SRCH_CHECK_BELOW: begin
          if (!seen) begin
            settle_found(v);
          end else begin
            view[v].hi_bound = {1'b0, view[v].probe};
            halve(v);
          end
        end
        SRCH_READ_SHORT: begin
          put_frame(v, OP_WITHDRAW, 8'h00, GAP_COMPARE, 1'b0, 1'b1, view[v].probe,
                    seen ? data[7:1] : SHORT_NONE, 1'b0);
          next_slot(v);
        end
        default: ;
      endcase
    end
    if (fresh_frames.size() > 0) begin
      f = fresh_frames.pop_back();
      f.last = 1'b1;
      fresh_frames.push_back(f);
    end
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: present queued requests, predict frames on each transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_frames(CHECK_VIEW, s_tuser[0], s_tdata[0], s_tdata[8:1]);
        foreach (fresh_frames[k]) pending_frames.push_back(fresh_frames[k]);
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (request_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_req.kind;
          s_tdata  <= {7'd0, next_req.data, next_req.seen};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Frame receiver: stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Frame monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("frame with nothing expected: tdata %h last %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        check_field("frame_address", pending_frames[0].frame_address, m_tdata[7:0]);
        check_field("frame_data", pending_frames[0].frame_data, m_tdata[15:8]);
        check_field("frame_tag", pending_frames[0].frame_tag, m_tdata[23:16]);
        check_field("gap_class", pending_frames[0].gap_class, m_tdata[25:24]);
        check_field("expects_answer", pending_frames[0].expects_answer, m_tdata[26]);
        check_field("found_address", pending_frames[0].found_address, m_tdata[50:27]);
        check_field("assigned_short", pending_frames[0].assigned_short, m_tdata[57:51]);
        check_field("found_valid", pending_frames[0].found_valid, m_tdata[58]);
        check_field("done_res", pending_frames[0].done_res, m_tdata[59]);
        check_field("last", pending_frames[0].last, m_tlast);
        void'(pending_frames.pop_front());
      end
    end
  end

  // Stimulus helpers

  // Queue one request and follow its frames to keep the device population in step
  task automatic add_request(logic kind, logic seen, logic [7:0] data);
    request_t r;
    if (kind == CMD_START || view[STIM_VIEW].stage != SRCH_IDLE) live_items++;
    predict_frames(STIM_VIEW, kind, seen, data);
    foreach (fresh_frames[k]) begin
      case (fresh_frames[k].frame_address)
        OP_SEARCH_H: bus_addr[23:16] = fresh_frames[k].frame_data;
        OP_SEARCH_M: bus_addr[15:8] = fresh_frames[k].frame_data;
        OP_SEARCH_L: bus_addr[7:0] = fresh_frames[k].frame_data;
        OP_COMPARE: if (fresh_frames[k].expects_answer) bus_wait = AWAIT_COMPARE;
        OP_QUERY_SHORT: bus_wait = AWAIT_SHORT;
        OP_TERMINATE: bus_wait = AWAIT_NONE;
        OP_WITHDRAW: begin
          for (int j = dev_addr.size() - 1; j >= 0; j--) begin
            if (dev_addr[j] == fresh_frames[k].found_address) begin
              dev_addr.delete(j);
              dev_short.delete(j);
            end
          end
        end
        default: ;
      endcase
    end
    r.kind = kind;
    r.seen = seen;
    r.data = data;
    request_q.push_back(r);
    queued_count++;
  endtask

  // Answer as the devices on the bus would, with a little noise
  task automatic bus_reply(output logic seen, output logic [7:0] data);
    logic       hit;
    logic [7:0] junk;
    hit  = 1'b0;
    junk = 8'($urandom);
    data = junk;
    if (bus_wait == AWAIT_COMPARE) begin
      foreach (dev_addr[j]) if (dev_addr[j] <= bus_addr) hit = 1'b1;
      seen = hit;
    end else if (bus_wait == AWAIT_SHORT) begin
      foreach (dev_addr[j]) begin
        if (dev_addr[j] == bus_addr) begin
          hit  = 1'b1;
          data = {dev_short[j], junk[0]};
        end
      end
      seen = hit && ($urandom_range(0, 9) != 0);
    end else begin
      seen = junk[1];
    end
    if ($urandom_range(0, 99) < 7) seen = !seen;
  endtask

  // One commissioning run over a fresh device population
  task automatic run_session(int ndev, int cap);
    logic       seen;
    logic [7:0] data;
    dev_addr.delete();
    dev_short.delete();
    repeat (ndev) begin
      case ($urandom_range(0, 9))
        0: dev_addr.push_back(24'd0);
        1: dev_addr.push_back(TOP_ADDR);
        2: dev_addr.push_back(TOP_ADDR - 24'd1);
        default: dev_addr.push_back(24'($urandom));
      endcase
      dev_short.push_back(7'($urandom_range(0, 127)));
    end
    add_request(CMD_START, 1'($urandom), 8'($urandom));
    while (view[STIM_VIEW].stage != SRCH_IDLE && live_items < cap) begin
      if ($urandom_range(0, 99) < 2) begin
        add_request(CMD_START, 1'($urandom), 8'($urandom));
      end else begin
        bus_reply(seen, data);
        add_request(CMD_ANSWER, seen, data);
      end
    end
    // stray answer, usually to an idle block
    if ($urandom_range(0, 3) == 0) add_request(CMD_ANSWER, 1'($urandom), 8'($urandom));
  endtask

  // Wait until every queued request has gone through and every frame has come
  task automatic settle();
    while (accepted_count != queued_count) @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    settle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_READONLY:  cfg.readonly_mode  = value[0];
      REG_SKIP_RAND: cfg.skip_randomise = value[0];
      REG_LIMIT:     cfg.short_limit    = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic ro, logic skip, logic [6:0] lim);
    write_reg(REG_READONLY, {31'd0, ro});
    write_reg(REG_SKIP_RAND, {31'd0, skip});
    write_reg(REG_LIMIT, {25'd0, lim});
  endtask

  initial begin
    clear_view(STIM_VIEW);
    clear_view(CHECK_VIEW);
    cfg.readonly_mode  = 1'b0;
    cfg.skip_randomise = 1'b0;
    cfg.short_limit    = LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Answer to an idle block, then a run with nobody at the top address
    add_request(CMD_ANSWER, 1'b1, 8'hFF);
    add_request(CMD_START, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    // Silence right below the top address: device at the top, next slot empty
    add_request(CMD_START, 1'b1, 8'hFF);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    // Restart while a search is in progress
    add_request(CMD_START, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'h55);
    add_request(CMD_START, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'hAA);

    // Read-only: reported short from both data extremes and from no answer
    write_reg(REG_READONLY, 32'd1);
    add_request(CMD_START, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'hFF);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'hAA);
    add_request(CMD_ANSWER, 1'b0, 8'h00);

    // Zero limit terminates right after the init frames
    write_reg(REG_LIMIT, 32'd0);
    add_request(CMD_START, 1'b0, 8'h00);

    // Skip randomise, limit one: terminate right after the first device
    set_config(1'b0, 1'b1, 7'd1);
    add_request(CMD_START, 1'b0, 8'h00);
    add_request(CMD_ANSWER, 1'b1, 8'h00);
    add_request(CMD_ANSWER, 1'b0, 8'h00);

    // Random runs over several settings
    live_items = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(1'b0, 1'b0, 7'd2);
        1: set_config(1'b1, 1'($urandom), 7'd127);
        2: set_config(1'b0, 1'b1, 7'd1);
        default: set_config(1'($urandom), 1'($urandom), 7'($urandom_range(1, 64)));
      endcase
      calm <= (p == 1);
      while (live_items < (p + 1) * RANDOM_ITEMS / 4) begin
        run_session($urandom_range(0, 3), (p + 1) * RANDOM_ITEMS / 4 + 40);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
